// File: src/ufrb_pkg.sv
// Package with shared constants and types of the UART FIFO register block.
`default_nettype none
package ufrb_pkg;
    localparam int DefaultRxDepth = 16;
    localparam int DefaultTxDepth = 16;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_LINE  = 2'd2;
    localparam logic [1:0] CMD_POP   = 2'd3;

    localparam logic [3:0] REG_DATA   = 4'd0;
    localparam logic [3:0] REG_STATUS = 4'd1;
    localparam logic [3:0] REG_LCR    = 4'd2;
    localparam logic [3:0] REG_DIVH   = 4'd3;
    localparam logic [3:0] REG_DIVL   = 4'd4;
    localparam logic [3:0] REG_CTRL   = 4'd5;
    localparam logic [3:0] REG_FLAGS  = 4'd6;
    localparam logic [3:0] REG_IID    = 4'd7;
    localparam logic [3:0] REG_IRDA   = 4'd8;
    localparam logic [3:0] REG_RTSCTL = 4'd9;
    localparam logic [3:0] REG_RTSLD  = 4'd10;
    localparam logic [3:0] REG_RTSTR  = 4'd11;
    localparam logic [3:0] REG_DRVEN  = 4'd12;
    localparam logic [3:0] REG_BAUD   = 4'd13;
    localparam logic [3:0] REG_RXTRIG = 4'd14;
    localparam logic [3:0] REG_TXTRIG = 4'd15;

    typedef struct packed {
        logic       exec;
        logic [1:0] cmd;
        logic       load_out;
    } ufrb_cmd_t;
endpackage
`default_nettype wire

// File: src/ufrb_ctrl.sv
// Controller for the request and result handshake of the UART register block.
`default_nettype none
module ufrb_ctrl
    import ufrb_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic [1:0] s_cmd,
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    output ufrb_cmd_t       dp_cmd
);
    localparam logic ST_EMPTY = 1'b0;
    localparam logic ST_FULL  = 1'b1;

    logic state_reg, state_next;
    logic take;

    assign s_ready = (state_reg == ST_EMPTY) || m_ready;
    assign take = s_valid && s_ready;
    assign m_valid = (state_reg == ST_FULL);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_EMPTY: if (take) state_next = ST_FULL;
            ST_FULL:  if (m_ready && !take) state_next = ST_EMPTY;
            default:  state_next = ST_EMPTY;
        endcase
    end

    always_comb begin
        dp_cmd.exec = take;
        dp_cmd.cmd = s_cmd;
        dp_cmd.load_out = take;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_EMPTY;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

// File: src/ufrb_dp.sv
// Datapath with FIFOs, registers and flags of the UART register block.
`default_nettype none
module ufrb_dp
    import ufrb_pkg::*;
#(
    parameter int RX_DEPTH = DefaultRxDepth,
    parameter int TX_DEPTH = DefaultTxDepth
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire ufrb_cmd_t   dp_cmd,
    input  wire logic [3:0]  register_index,
    input  wire logic [31:0] write_data,
    input  wire logic [7:0]  line_char,
    input  wire logic        cts_level,
    output logic [31:0]      read_data,
    output logic [7:0]       tx_char,
    output logic             tx_char_valid,
    output logic             irq_request,
    output logic             rx_hold,
    output logic             tx_running
);
    localparam int RAW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int TAW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int RPW = RAW + 1;
    localparam int TPW = TAW + 1;
    localparam logic [RPW-1:0] RxDepthV = RPW'(RX_DEPTH);
    localparam logic [TPW-1:0] TxDepthV = TPW'(TX_DEPTH);
    localparam logic [RPW-1:0] RxLast = RPW'(2 * RX_DEPTH - 1);
    localparam logic [TPW-1:0] TxLast = TPW'(2 * TX_DEPTH - 1);

    logic [7:0] rx_mem [RX_DEPTH];
    logic [7:0] tx_mem [TX_DEPTH];
    logic [RPW-1:0] rx_wp_reg, rx_wp_next, rx_rp_reg, rx_rp_next;
    logic [TPW-1:0] tx_wp_reg, tx_wp_next, tx_rp_reg, tx_rp_next;
    logic [7:0] flag_reg, flag_next;
    logic [3:0] ist_reg, ist_next;
    logic [31:0] ctrl_reg, ctrl_next;
    logic [31:0] plain_reg [8];
    logic [4:0] rxtrig_reg, rxtrig_next, txtrig_reg, txtrig_next;
    logic hold_reg, hold_next, run_reg, run_next;
    logic [31:0] rd_reg, rd_next;
    logic [7:0] tc_reg;
    logic tv_reg, tv_next;

    logic [RPW-1:0] rx_cnt, rx_cnt_pop, rx_cnt_push;
    logic [TPW-1:0] tx_cnt, tx_cnt_pop;
    logic [RAW-1:0] rx_wslot, rx_rslot;
    logic [TAW-1:0] tx_wslot, tx_rslot;
    logic rx_push, rx_pop, tx_push, tx_pop;
    logic [5:0] rx_room_w, tx_room_w, tx_room_a;

    function automatic logic [RPW-1:0] rinc(input logic [RPW-1:0] p);
        rinc = (p == RxLast) ? '0 : p + 1'b1;
    endfunction
    function automatic logic [TPW-1:0] tinc(input logic [TPW-1:0] p);
        tinc = (p == TxLast) ? '0 : p + 1'b1;
    endfunction
    function automatic logic [RPW-1:0] rcnt(input logic [RPW-1:0] w, input logic [RPW-1:0] r);
        logic [RPW:0] d;
        d = {1'b0, w} - {1'b0, r};
        if (w < r) d = d + (RPW+1)'(2 * RX_DEPTH);
        rcnt = d[RPW-1:0];
    endfunction
    function automatic logic [TPW-1:0] tcnt(input logic [TPW-1:0] w, input logic [TPW-1:0] r);
        logic [TPW:0] d;
        d = {1'b0, w} - {1'b0, r};
        if (w < r) d = d + (TPW+1)'(2 * TX_DEPTH);
        tcnt = d[TPW-1:0];
    endfunction
    function automatic logic [RAW-1:0] rslot(input logic [RPW-1:0] p);
        logic [RPW-1:0] s;
        s = (p >= RxDepthV) ? p - RxDepthV : p;
        rslot = s[RAW-1:0];
    endfunction
    function automatic logic [TAW-1:0] tslot(input logic [TPW-1:0] p);
        logic [TPW-1:0] s;
        s = (p >= TxDepthV) ? p - TxDepthV : p;
        tslot = s[TAW-1:0];
    endfunction

    assign rx_cnt = rcnt(rx_wp_reg, rx_rp_reg);
    assign tx_cnt = tcnt(tx_wp_reg, tx_rp_reg);
    assign rx_wslot = rslot(rx_wp_reg);
    assign rx_rslot = rslot(rx_rp_reg);
    assign tx_wslot = tslot(tx_wp_reg);
    assign tx_rslot = tslot(tx_rp_reg);
    assign rx_cnt_pop = rx_cnt - 1'b1;
    assign rx_cnt_push = rx_cnt + 1'b1;
    assign tx_cnt_pop = tx_cnt - 1'b1;
    assign rx_room_w = 6'(RX_DEPTH) - 6'(rx_cnt);
    assign tx_room_w = 6'(TX_DEPTH) - 6'(tx_cnt);

    always_comb begin
        rx_wp_next = rx_wp_reg; rx_rp_next = rx_rp_reg;
        tx_wp_next = tx_wp_reg; tx_rp_next = tx_rp_reg;
        flag_next = flag_reg; ist_next = ist_reg; ctrl_next = ctrl_reg;
        rxtrig_next = rxtrig_reg; txtrig_next = txtrig_reg;
        hold_next = hold_reg; run_next = run_reg;
        rd_next = '0; tv_next = 1'b0;
        rx_push = 1'b0; rx_pop = 1'b0; tx_push = 1'b0; tx_pop = 1'b0;
        tx_room_a = tx_room_w;
        case (dp_cmd.cmd)
            CMD_READ: begin
                case (register_index)
                    REG_STATUS: rd_next = plain_reg[0];
                    REG_LCR:    rd_next = plain_reg[1];
                    REG_DIVH:   rd_next = plain_reg[2];
                    REG_DIVL:   rd_next = plain_reg[3];
                    REG_RTSLD:  rd_next = plain_reg[4];
                    REG_RTSTR:  rd_next = plain_reg[5];
                    REG_DRVEN:  rd_next = plain_reg[6];
                    REG_BAUD:   rd_next = plain_reg[7];
                    REG_CTRL:   rd_next = ctrl_reg;
                    REG_FLAGS:  rd_next = {24'd0, flag_reg[7:1], cts_level};
                    REG_IID:    rd_next = {28'd0, ist_reg & ctrl_reg[6:3]};
                    REG_RXTRIG: rd_next = {27'd0, rxtrig_reg};
                    REG_TXTRIG: rd_next = {27'd0, txtrig_reg};
                    REG_DATA: begin
                        if (ctrl_reg[0]) begin
                            if (rx_cnt != '0) begin
                                rx_pop = 1'b1;
                                rx_rp_next = rinc(rx_rp_reg);
                                flag_next[6] = 1'b0;
                                if (5'(rx_cnt_pop) < rxtrig_reg) ist_next[1] = 1'b0;
                            end
                            if (rx_cnt == '0 || rx_cnt_pop == '0) begin
                                ist_next[1] = 1'b0;
                                ist_next[3] = 1'b0;
                                flag_next[4] = 1'b1;
                            end
                            hold_next = 1'b0;
                        end
                    end
                    default: rd_next = '0;
                endcase
            end
            CMD_WRITE: begin
                case (register_index)
                    REG_DATA: begin
                        if (tx_room_w != '0) begin
                            tx_push = 1'b1;
                            tx_wp_next = tinc(tx_wp_reg);
                            tx_room_a = tx_room_w - 1'b1;
                        end
                        flag_next[7] = 1'b0;
                        flag_next[3] = 1'b1;
                        if (tx_room_a != '0) begin
                            flag_next[5] = 1'b0;
                            if (tx_room_a >= {1'b0, txtrig_reg}) ist_next[2] = 1'b1;
                        end else begin
                            ist_next[2] = 1'b1;
                            flag_next[5] = 1'b1;
                        end
                        run_next = 1'b1;
                    end
                    REG_CTRL: begin
                        ctrl_next = write_data;
                        if (write_data[0] && !ctrl_reg[0]) begin
                            rx_wp_next = '0; rx_rp_next = '0;
                            tx_wp_next = '0; tx_rp_next = '0;
                            flag_next[4] = 1'b1; flag_next[6] = 1'b0;
                            flag_next[7] = 1'b1; flag_next[5] = 1'b0;
                            flag_next[3] = 1'b0;
                            ist_next[1] = 1'b0; ist_next[2] = 1'b0;
                            hold_next = 1'b0;
                        end
                    end
                    REG_IID:    ist_next[0] = 1'b0;
                    REG_RXTRIG: rxtrig_next = write_data[4:0];
                    REG_TXTRIG: txtrig_next = write_data[4:0];
                    default: ;
                endcase
            end
            CMD_LINE: begin
                if (rx_room_w != '0) begin
                    rx_push = 1'b1;
                    rx_wp_next = rinc(rx_wp_reg);
                    if (rx_room_w == 6'd1) hold_next = 1'b1;
                end
                flag_next[4] = 1'b0;
                if (rx_room_w <= 6'd1) flag_next[6] = 1'b1;
                ist_next[3] = 1'b1;
                if (rx_room_w != '0) begin
                    if (6'(rx_cnt_push) >= {1'b0, rxtrig_reg}) ist_next[1] = 1'b1;
                end else if (6'(rx_cnt) >= {1'b0, rxtrig_reg}) begin
                    ist_next[1] = 1'b1;
                end
            end
            default: begin
                if (tx_cnt != '0) begin
                    tx_pop = 1'b1;
                    tv_next = 1'b1;
                    tx_rp_next = tinc(tx_rp_reg);
                end
                if (tx_cnt == '0 || tx_cnt_pop == '0) begin
                    flag_next[7] = 1'b1;
                    flag_next[3] = 1'b0;
                    flag_next[5] = 1'b0;
                    ist_next[2] = 1'b1;
                    run_next = 1'b0;
                end else begin
                    if (6'(TX_DEPTH) - 6'(tx_cnt_pop) <= {1'b0, txtrig_reg})
                        ist_next[2] = 1'b1;
                    flag_next[5] = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.exec && rx_push) rx_mem[rx_wslot] <= line_char;
        if (dp_cmd.exec && tx_push) tx_mem[tx_wslot] <= write_data[7:0];
        if (dp_cmd.load_out) begin
            rd_reg <= rx_pop ? {24'd0, rx_mem[rx_rslot]} : rd_next;
            tc_reg <= tx_pop ? tx_mem[tx_rslot] : 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_wp_reg <= '0; rx_rp_reg <= '0; tx_wp_reg <= '0; tx_rp_reg <= '0;
            flag_reg <= '0; ist_reg <= '0; ctrl_reg <= '0;
            rxtrig_reg <= 5'd8; txtrig_reg <= 5'd8;
            hold_reg <= 1'b0; run_reg <= 1'b0; tv_reg <= 1'b0;
            for (int i = 0; i < 8; i++) plain_reg[i] <= '0;
        end else if (dp_cmd.exec) begin
            rx_wp_reg <= rx_wp_next; rx_rp_reg <= rx_rp_next;
            tx_wp_reg <= tx_wp_next; tx_rp_reg <= tx_rp_next;
            flag_reg <= flag_next; ist_reg <= ist_next; ctrl_reg <= ctrl_next;
            rxtrig_reg <= rxtrig_next; txtrig_reg <= txtrig_next;
            hold_reg <= hold_next; run_reg <= run_next; tv_reg <= tv_next;
            if (dp_cmd.cmd == CMD_WRITE) begin
                case (register_index)
                    REG_STATUS: plain_reg[0] <= write_data;
                    REG_LCR:    plain_reg[1] <= write_data;
                    REG_DIVH:   plain_reg[2] <= write_data;
                    REG_DIVL:   plain_reg[3] <= write_data;
                    REG_RTSLD:  plain_reg[4] <= {24'd0, write_data[7:0]};
                    REG_RTSTR:  plain_reg[5] <= {24'd0, write_data[7:0]};
                    REG_DRVEN:  plain_reg[6] <= {30'd0, write_data[1:0]};
                    REG_BAUD:   plain_reg[7] <= {31'd0, write_data[0]};
                    default: ;
                endcase
            end
        end
    end

    assign read_data = rd_reg;
    assign tx_char = tc_reg;
    assign tx_char_valid = tv_reg;
    assign irq_request = |(ist_reg & ctrl_reg[6:3]);
    assign rx_hold = hold_reg;
    assign tx_running = run_reg;
endmodule
`default_nettype wire

// File: src/uart_fifo_register_block_unit.sv
// Top level of the UART FIFO register block.
// Latency: a request's result is shown in the cycle after it is accepted.
// Throughput: one request per cycle while each result is taken (m_tready high), set by the single-step register update.
// A new request is taken while the previous result is being taken.
// Reset (aresetn low, synchronous) empties both FIFOs and clears registers;
// both trigger levels return to 8.
`default_nettype none
module uart_fifo_register_block_unit
    import ufrb_pkg::*;
#(
    parameter int RX_DEPTH = DefaultRxDepth,
    parameter int TX_DEPTH = DefaultTxDepth
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // register_index[3:0], write_data[35:4], line_char[43:36], cts_level[44], zero fill
    input  wire logic [47:0] s_tdata,
    // command
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_data[31:0], tx_char[39:32], tx_char_valid[40], irq_request[41],
    // rx_hold[42], tx_running[43], zero fill
    output logic [47:0]      m_tdata
);
    ufrb_cmd_t dp_cmd;
    logic [31:0] rd;
    logic [7:0] tc;
    logic tv, irq, hold, run;

    ufrb_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_tvalid), .s_cmd(s_tuser),
        .s_ready(s_tready), .m_valid(m_tvalid), .m_ready(m_tready), .dp_cmd(dp_cmd)
    );

    ufrb_dp #(.RX_DEPTH(RX_DEPTH), .TX_DEPTH(TX_DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .dp_cmd(dp_cmd),
        .register_index(s_tdata[3:0]), .write_data(s_tdata[35:4]),
        .line_char(s_tdata[43:36]), .cts_level(s_tdata[44]),
        .read_data(rd), .tx_char(tc), .tx_char_valid(tv), .irq_request(irq),
        .rx_hold(hold), .tx_running(run)
    );

    assign m_tdata = {4'd0, run, hold, irq, tv, tc, rd};
endmodule
`default_nettype wire

// File: src/ufrb_checker.sv
// Port checker for the UART FIFO register block.
`default_nettype none
module ufrb_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata
);
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready) else $error("input stalled with no pending result");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result changed");
    a_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[40] |-> m_tdata[39:32] == 8'd0) else $error("stray tx byte");
    a_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid) else $error("result missing");
endmodule

bind uart_fifo_register_block_unit ufrb_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
